@@ rtl/sector_cache_clock_directory_assert.svh @@
// Assertion macros used by the directory RTL.
`ifndef SECTOR_CACHE_CLOCK_DIRECTORY_ASSERT_SVH
`define SECTOR_CACHE_CLOCK_DIRECTORY_ASSERT_SVH
`ifndef SYNTHESIS
`define SCCD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define SCCD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define SCCD_ASSERT_ALWAYS(label, clk, rst, cond)
`define SCCD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/sccd_pkg.sv @@
`timescale 1ns / 1ps
package sccd_pkg;
   localparam int ENTRIES     = 64;
   localparam int SECTOR_BITS = 32;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SLOT_W      = 6;
   localparam int SEC_W       = 32;
   localparam int CNT_W       = 32;
   localparam int KIND_W      = 2;

   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;
   localparam logic [KIND_W-1:0] KIND_INVAL = 2'd3;

   typedef enum logic [1:0] {OP_READ, OP_WRITE, OP_FLUSH, OP_INVAL} op_type;
   typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_SWEEP, ST_SCAN} state_type;

   typedef struct packed {
      op_type                 op;
      logic [SECTOR_BITS-1:0] sector;
   } item_type;

   // lowest set bit of a directory-wide vector
   function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) idx = IDX_W'(i);
      end
      return idx;
   endfunction
endpackage

@@ rtl/sccd_front.sv @@
`timescale 1ns / 1ps
module sccd_front import sccd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [SEC_W-1:0]  req_sector,
   output logic              item_valid,
   output item_type          item,
   input  logic              item_pop
);
   item_type   q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   item_type   cls;
   logic       push;

   always_comb begin
      case (req_kind)
         KIND_READ:  cls.op = OP_READ;
         KIND_WRITE: cls.op = OP_WRITE;
         KIND_FLUSH: cls.op = OP_FLUSH;
         KIND_INVAL: cls.op = OP_INVAL;
         default:    cls.op = OP_READ;
      endcase
      cls.sector = req_sector[SECTOR_BITS-1:0];
   end

   assign req_ready  = (cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      if (push) begin
         wr_in  = ~wr_ff;
         cnt_in = cnt_in + 2'd1;
      end
      if (item_pop && item_valid) begin
         rd_in  = ~rd_ff;
         cnt_in = cnt_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= cls;
   end
endmodule

@@ rtl/sccd_back.sv @@
`timescale 1ns / 1ps
`include "sector_cache_clock_directory_assert.svh"
module sccd_back import sccd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  item_type          item,
   output logic              item_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic              rsp_hit,
   output logic              rsp_fill_needed,
   output logic              rsp_writeback_valid,
   output logic [SEC_W-1:0]  rsp_writeback_sector,
   output logic [CNT_W-1:0]  rsp_hit_count,
   output logic [CNT_W-1:0]  rsp_miss_count,
   output logic              rsp_last
);
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [SECTOR_BITS-1:0] sec_ff, sec_in;
   logic [SECTOR_BITS-1:0] tags_ff [ENTRIES];
   logic [ENTRIES-1:0]     valid_ff, valid_in, dirty_ff, dirty_in, clkb_ff, clkb_in;
   logic [IDX_W-1:0]       hand_ff, hand_in, ptr_ff, ptr_in;
   logic [CNT_W-1:0]       hits_ff, hits_in, misses_ff, misses_in;

   logic                   rv_ff, rv_in;
   logic [SLOT_W-1:0]      rslot_ff, rslot_in;
   logic                   rhit_ff, rhit_in, rfill_ff, rfill_in, rwbv_ff, rwbv_in;
   logic [SEC_W-1:0]       rwbs_ff, rwbs_in;
   logic [CNT_W-1:0]       rhc_ff, rhc_in, rmc_ff, rmc_in;
   logic                   rlast_ff, rlast_in;

   logic                   tag_we;
   logic [IDX_W-1:0]       tag_idx;
   logic [ENTRIES-1:0]     hit_vec, pend;
   logic                   out_free, is_wr;
   logic [IDX_W-1:0]       pick;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (tags_ff[i] == sec_ff);
      end
   end

   assign pend     = valid_ff & dirty_ff;
   assign out_free = !rv_ff || rsp_ready;
   assign is_wr    = (op_ff == OP_WRITE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      sec_in    = sec_ff;
      valid_in  = valid_ff;
      dirty_in  = dirty_ff;
      clkb_in   = clkb_ff;
      hand_in   = hand_ff;
      ptr_in    = ptr_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      item_pop  = 1'b0;
      tag_we    = 1'b0;
      tag_idx   = '0;
      pick      = '0;
      rv_in     = rv_ff && !rsp_ready;
      rslot_in  = rslot_ff;
      rhit_in   = rhit_ff;
      rfill_in  = rfill_ff;
      rwbv_in   = rwbv_ff;
      rwbs_in   = rwbs_ff;
      rhc_in    = rhc_ff;
      rmc_in    = rmc_ff;
      rlast_in  = rlast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               op_in    = item.op;
               sec_in   = item.sector;
               if (item.op == OP_READ || item.op == OP_WRITE) begin
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_SCAN;
                  if (item.op == OP_INVAL) begin
                     hits_in   = '0;
                     misses_in = '0;
                  end
               end
            end
         end
         ST_LOOKUP: begin
            if (|hit_vec) begin
               if (out_free) begin
                  pick          = first_set(hit_vec);
                  clkb_in[pick] = 1'b0;
                  if (is_wr) dirty_in[pick] = 1'b1;
                  if (hits_ff != CNT_MAX) hits_in = hits_ff + CNT_W'(1);
                  rv_in    = 1'b1;
                  rslot_in = SLOT_W'(pick);
                  rhit_in  = 1'b1;
                  rfill_in = 1'b0;
                  rwbv_in  = 1'b0;
                  rwbs_in  = '0;
                  rhc_in   = hits_in;
                  rmc_in   = misses_ff;
                  rlast_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (!(&valid_ff)) begin
               if (out_free) begin
                  pick     = first_set(~valid_ff);
                  tag_we   = 1'b1;
                  tag_idx  = pick;
                  valid_in[pick] = 1'b1;
                  dirty_in[pick] = is_wr;
                  clkb_in[pick]  = 1'b0;
                  if (misses_ff != CNT_MAX) misses_in = misses_ff + CNT_W'(1);
                  rv_in    = 1'b1;
                  rslot_in = SLOT_W'(pick);
                  rhit_in  = 1'b0;
                  rfill_in = !is_wr;
                  rwbv_in  = 1'b0;
                  rwbs_in  = '0;
                  rhc_in   = hits_ff;
                  rmc_in   = misses_in;
                  rlast_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               ptr_in   = hand_ff;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // pass over entries with a clear clock bit, marking them
            if (!clkb_ff[ptr_ff]) begin
               clkb_in[ptr_ff] = 1'b1;
               ptr_in = (ptr_ff == IDX_W'(ENTRIES - 1)) ? '0 : ptr_ff + IDX_W'(1);
            end else if (out_free) begin
               tag_we   = 1'b1;
               tag_idx  = ptr_ff;
               dirty_in[ptr_ff] = is_wr;
               clkb_in[ptr_ff]  = 1'b0;
               hand_in  = (ptr_ff == IDX_W'(ENTRIES - 1)) ? '0 : ptr_ff + IDX_W'(1);
               if (misses_ff != CNT_MAX) misses_in = misses_ff + CNT_W'(1);
               rv_in    = 1'b1;
               rslot_in = SLOT_W'(ptr_ff);
               rhit_in  = 1'b0;
               rfill_in = !is_wr;
               rwbv_in  = dirty_ff[ptr_ff];
               rwbs_in  = dirty_ff[ptr_ff] ? SEC_W'(tags_ff[ptr_ff]) : '0;
               rhc_in   = hits_ff;
               rmc_in   = misses_in;
               rlast_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (pend == '0) begin
               if (op_ff == OP_INVAL) begin
                  valid_in = '0;
                  dirty_in = '0;
               end
               state_in = ST_IDLE;
            end else if (out_free) begin
               pick           = first_set(pend);
               dirty_in[pick] = 1'b0;
               rv_in    = 1'b1;
               rslot_in = SLOT_W'(pick);
               rhit_in  = 1'b0;
               rfill_in = 1'b0;
               rwbv_in  = 1'b1;
               rwbs_in  = SEC_W'(tags_ff[pick]);
               rhc_in   = hits_ff;
               rmc_in   = misses_ff;
               rlast_in = ((pend & (pend - ENTRIES'(1))) == '0);
               if (rlast_in) begin
                  if (op_ff == OP_INVAL) begin
                     valid_in = '0;
                     dirty_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         dirty_ff  <= '0;
         clkb_ff   <= '0;
         hand_ff   <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         dirty_ff  <= dirty_in;
         clkb_ff   <= clkb_in;
         hand_ff   <= hand_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      sec_ff   <= sec_in;
      ptr_ff   <= ptr_in;
      rslot_ff <= rslot_in;
      rhit_ff  <= rhit_in;
      rfill_ff <= rfill_in;
      rwbv_ff  <= rwbv_in;
      rwbs_ff  <= rwbs_in;
      rhc_ff   <= rhc_in;
      rmc_ff   <= rmc_in;
      rlast_ff <= rlast_in;
      if (tag_we) tags_ff[tag_idx] <= sec_ff;
   end

   assign rsp_valid            = rv_ff;
   assign rsp_slot             = rslot_ff;
   assign rsp_hit              = rhit_ff;
   assign rsp_fill_needed      = rfill_ff;
   assign rsp_writeback_valid  = rwbv_ff;
   assign rsp_writeback_sector = rwbs_ff;
   assign rsp_hit_count        = rhc_ff;
   assign rsp_miss_count       = rmc_ff;
   assign rsp_last             = rlast_ff;

   `SCCD_ASSERT_ALWAYS(a_dirty_valid, clock, reset, (dirty_ff & ~valid_ff) == '0)
   `SCCD_ASSERT_IMPLIES(a_sweep_full, clock, reset, state_ff == ST_SWEEP, &valid_ff)
   `SCCD_ASSERT_IMPLIES(a_hit_clean, clock, reset, rv_ff && rhit_ff, !rfill_ff && !rwbv_ff)
   `SCCD_ASSERT_IMPLIES(a_pop_idle, clock, reset, item_pop, state_ff == ST_IDLE)
endmodule

@@ rtl/sector_cache_clock_directory.sv @@
`timescale 1ns / 1ps
// Read/write: on a hit or a free slot the result is registered from the lookup state; a full
// cache first sweeps the clock hand over entries with a clear clock bit, marking them.
// Flush/invalidate: one writeback result per dirty entry, lowest slot first, last flagged.
// Requests are handled one at a time; the back end takes the next only when back in idle.
// Synchronous active-high reset empties the directory and clears counters.
module sector_cache_clock_directory import sccd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [SEC_W-1:0]  req_sector,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic              rsp_hit,
   output logic              rsp_fill_needed,
   output logic              rsp_writeback_valid,
   output logic [SEC_W-1:0]  rsp_writeback_sector,
   output logic [CNT_W-1:0]  rsp_hit_count,
   output logic [CNT_W-1:0]  rsp_miss_count,
   output logic              rsp_last
);
   logic     item_valid, item_pop;
   item_type item;

   sccd_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_sector,
      .item_valid, .item, .item_pop
   );

   sccd_back u_back (
      .clock, .reset, .item_valid, .item, .item_pop,
      .rsp_valid, .rsp_ready, .rsp_slot, .rsp_hit, .rsp_fill_needed,
      .rsp_writeback_valid, .rsp_writeback_sector, .rsp_hit_count,
      .rsp_miss_count, .rsp_last
   );
endmodule

@@ sim/sector_cache_clock_directory_tb.sv @@
`timescale 1ns / 1ps
module sector_cache_clock_directory_tb;
   import sccd_pkg::*;

   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic              fill;
      logic              wbv;
      logic [SEC_W-1:0]  wbs;
      logic [CNT_W-1:0]  hits;
      logic [CNT_W-1:0]  misses;
      logic              last;
   } access_result_type;

   class directory_scoreboard;
      logic [SEC_W-1:0]   tags [ENTRIES];
      logic [ENTRIES-1:0] valid_v, dirty_v, clk_v;
      logic [IDX_W-1:0]   hand;
      logic [CNT_W-1:0]   hits, misses;
      access_result_type  pending[$];
      int                 errors;
      int                 checked;

      function void clear();
         valid_v = '0; dirty_v = '0; clk_v = '0; hand = '0;
         hits = '0; misses = '0; pending.delete(); errors = 0; checked = 0;
      endfunction

      function void push(logic [SLOT_W-1:0] s, logic h, logic f, logic wv,
                         logic [SEC_W-1:0] ws, logic l);
         access_result_type r;
         r.slot = s; r.hit = h; r.fill = f; r.wbv = wv; r.wbs = wv ? ws : '0;
         r.hits = hits; r.misses = misses; r.last = l;
         pending.push_back(r);
      endfunction

      function void write_back_dirty();
         int n;
         n = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_v[i] && dirty_v[i]) begin
               push(SLOT_W'(i), 1'b0, 1'b0, 1'b1, tags[i], 1'b0);
               dirty_v[i] = 1'b0;
               n++;
            end
         end
         if (n > 0) pending[pending.size()-1].last = 1'b1;
      endfunction

      function void note_request(op_type op, logic [SEC_W-1:0] sec);
         int slot;
         bit found;
         logic wv;
         logic [SEC_W-1:0] ws;
         int h;
         found = 0; slot = 0; wv = 0; ws = '0;
         if (op == OP_FLUSH) begin
            write_back_dirty();
            return;
         end
         if (op == OP_INVAL) begin
            hits = '0; misses = '0;
            write_back_dirty();
            valid_v = '0; dirty_v = '0;
            return;
         end
         for (int i = 0; i < ENTRIES && !found; i++)
            if (valid_v[i] && tags[i] == sec) begin
               slot = i; found = 1;
            end
         if (found) begin
            clk_v[slot] = 1'b0;
            if (op == OP_WRITE) dirty_v[slot] = 1'b1;
            if (hits != '1) hits++;
            push(SLOT_W'(slot), 1'b1, 1'b0, 1'b0, '0, 1'b1);
            return;
         end
         for (int i = 0; i < ENTRIES && !found; i++)
            if (!valid_v[i]) begin
               slot = i; found = 1;
            end
         if (!found) begin
            h = hand;
            while (!clk_v[h]) begin
               clk_v[h] = 1'b1;
               h = (h + 1) % ENTRIES;
            end
            slot = h;
            if (dirty_v[slot]) begin
               wv = 1; ws = tags[slot];
            end
            hand = IDX_W'((slot + 1) % ENTRIES);
         end
         tags[slot] = sec;
         valid_v[slot] = 1'b1;
         dirty_v[slot] = (op == OP_WRITE);
         clk_v[slot] = 1'b0;
         if (misses != '1) misses++;
         push(SLOT_W'(slot), 1'b0, op == OP_READ, wv, ws, 1'b1);
      endfunction

      function void check_result(access_result_type a);
         access_result_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result slot %0d", $time, a.slot);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.slot !== e.slot) report("slot", 64'(e.slot), 64'(a.slot));
         if (a.hit !== e.hit) report("hit", 64'(e.hit), 64'(a.hit));
         if (a.fill !== e.fill) report("fill_needed", 64'(e.fill), 64'(a.fill));
         if (a.wbv !== e.wbv) report("writeback_valid", 64'(e.wbv), 64'(a.wbv));
         if (a.wbs !== e.wbs) report("writeback_sector", 64'(e.wbs), 64'(a.wbs));
         if (a.hits !== e.hits) report("hit_count", 64'(e.hits), 64'(a.hits));
         if (a.misses !== e.misses) report("miss_count", 64'(e.misses), 64'(a.misses));
         if (a.last !== e.last) report("last", 64'(e.last), 64'(a.last));
      endfunction

      function void report(string f, logic [63:0] e, logic [63:0] a);
         $display("%0t: %s mismatch expected %0h actual %0h", $time, f, e, a);
         errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [KIND_W-1:0] req_kind = KIND_READ;
   logic [SEC_W-1:0] req_sector = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [SLOT_W-1:0] rsp_slot;
   logic rsp_hit, rsp_fill_needed, rsp_writeback_valid, rsp_last;
   logic [SEC_W-1:0] rsp_writeback_sector;
   logic [CNT_W-1:0] rsp_hit_count, rsp_miss_count;

   directory_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_off;
   int requests_sent;

   always #4 clock = ~clock;

   sector_cache_clock_directory u_dut (.*);

   // keep valid high between back-to-back requests; drop it only while idling
   task automatic send_request(logic [KIND_W-1:0] k, logic [SEC_W-1:0] s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_sector <= s;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op_type'(k), s);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // pick from a small working set so hits and sweeps are common
   function automatic logic [SEC_W-1:0] pick_sector(int pool);
      case ($urandom_range(3))
         0: return $urandom();
         default: return 32'h1000_0000 + $urandom_range(pool - 1);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result('{rsp_slot, rsp_hit, rsp_fill_needed, rsp_writeback_valid,
                              rsp_writeback_sector, rsp_hit_count, rsp_miss_count,
                              rsp_last});
         end
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #4_000_000;
      $display("sector_cache_clock_directory test failed");
      $finish;
   end

   initial begin
      logic [KIND_W-1:0] k;
      sb = new();
      sb.clear();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 0;
      requests_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty flush/invalidate, field extremes, flush/invalidate of dirty entries
      send_request(KIND_FLUSH, '0);
      send_request(KIND_INVAL, '1);
      send_request(KIND_READ, '0);
      send_request(KIND_WRITE, '1);
      send_request(KIND_READ, '1);
      send_request(KIND_WRITE, 32'h5555_5555);
      send_request(KIND_READ, 32'hAAAA_AAAA);
      send_request(KIND_FLUSH, '0);
      send_request(KIND_WRITE, '0);
      send_request(KIND_INVAL, '0);
      send_request(KIND_READ, '1);
      drain();

      // fill the cache past capacity to force clock sweeps with writebacks
      for (int i = 0; i < 70; i++)
         send_request((i % 2) ? KIND_WRITE : KIND_READ, 32'h2000_0000 + i);
      send_request(KIND_FLUSH, '0);
      drain();

      // stuff requests while the receiver holds off
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 8; i++) send_request(KIND_WRITE, 32'h3000_0000 + i);
      join
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 31 : 61) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 31 : 61) : 0;
         for (int i = 0; i < 20; i++) begin
            k = ($urandom_range(19) == 0) ? KIND_FLUSH :
                ($urandom_range(39) == 0) ? KIND_INVAL :
                ($urandom_range(1) == 0) ? KIND_READ : KIND_WRITE;
            send_request(k, pick_sector(ph == 0 ? 40 : 90));
         end
      end
      send_request(KIND_INVAL, '0);
      drain();
      repeat (100) @(posedge clock);

      $display("Covered %0d requests and %0d results: hits, fills, clock sweeps,",
               requests_sent, sb.checked);
      $display("dirty writebacks, flush and invalidate under idle and stall phases.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("sector_cache_clock_directory test passed");
      end else begin
         $display("sector_cache_clock_directory test failed");
      end
      $finish;
   end
endmodule
